// ----- hdl/ndml_pkg.sv -----
// ndml_pkg: shared constants, codes and types of the nearest defined map lookup
// used by ndml_walk and nearest_defined_map_lookup; no dependencies
package ndml_pkg;

	localparam int DEPTH = 1024;
	localparam int AW    = $clog2(DEPTH);
	localparam int LW    = 11;
	localparam int VW    = 10;
	localparam int EW    = VW + 1;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	localparam logic [1:0] DIR_DOWN    = 2'd0;
	localparam logic [1:0] DIR_UP      = 2'd1;
	localparam logic [1:0] DIR_NEAREST = 2'd2;
	localparam logic [1:0] DIR_BAD     = 2'd3;

	// control from the sequencer to the walk unit
	typedef struct packed {
		logic          start;
		logic          step;
		logic [AW-1:0] idx;
		logic [1:0]    dir;
		logic [LW-1:0] len;
	} walk_ctl_t;

	// next probe address offered by the walk unit
	typedef struct packed {
		logic          avail;
		logic [AW-1:0] addr;
	} walk_t;

endpackage

// ----- hdl/ndml_walk.sv -----
// ndml_walk: probe order generator for one search, one address per step
// keeps a lower and an upper pointer; depends on ndml_pkg
module ndml_walk
	import ndml_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  walk_ctl_t ctl,
	output walk_t     walk
);

	logic          center_q;
	logic [AW-1:0] ctr_q;
	logic [AW-1:0] lo_q;
	logic          lo_ok_q;
	logic [LW-1:0] hi_q;
	logic          turn_lo_q;
	logic [1:0]    dir_q;
	logic [LW-1:0] len_q;
	logic          hi_ok;
	logic          use_lo;

	assign hi_ok = hi_q < len_q;

	always_comb begin
		unique case (dir_q)
			DIR_DOWN: use_lo = lo_ok_q;
			DIR_UP:   use_lo = !hi_ok;
			default:  use_lo = lo_ok_q & (turn_lo_q | !hi_ok);
		endcase
	end

	assign walk.avail = center_q | lo_ok_q | hi_ok;
	assign walk.addr  = center_q ? ctr_q : (use_lo ? lo_q : hi_q[AW-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q  <= 1'b0;
			lo_ok_q   <= 1'b0;
			turn_lo_q <= 1'b1;
			dir_q     <= DIR_DOWN;
			len_q     <= '0;
			hi_q      <= '0;
		end else if (ctl.start) begin
			center_q  <= 1'b1;
			lo_ok_q   <= ctl.idx != '0;
			turn_lo_q <= 1'b1;
			dir_q     <= ctl.dir;
			len_q     <= ctl.len;
			hi_q      <= LW'(ctl.idx) + LW'(1);
		end else if (ctl.step) begin
			priority if (center_q) begin
				center_q <= 1'b0;
			end else if (use_lo) begin
				if (lo_q == '0) lo_ok_q <= 1'b0;
				turn_lo_q <= 1'b0;
			end else begin
				hi_q      <= hi_q + LW'(1);
				turn_lo_q <= 1'b1;
			end
		end
	end

	// center and lower pointer hold payload only
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			ctr_q <= ctl.idx;
			lo_q  <= ctl.idx - AW'(1);
		end else if (ctl.step && !center_q && use_lo && lo_q != '0) begin
			lo_q <= lo_q - AW'(1);
		end
	end

endmodule

// ----- hdl/nearest_defined_map_lookup.sv -----
// nearest_defined_map_lookup: position map with nearest defined entry search
// top level; depends on ndml_pkg and ndml_walk
//
// Channels: cfg (cfg_valid/cfg_ready, cfg_data = map_length, always ready),
// input words (in_valid/in_ready) and result words (out_valid/out_ready).
// A write word (kind 0) sets or clears one entry in the accept cycle and gives
// no result; the block is ready again in the next cycle.
// A query word (kind 1) walks the map through one single-port read, one probe
// per cycle with the check in the cycle after each probe; it probes at most the
// length in use, and the block is not ready while it searches.
// An out-of-range index or a bad direction gives not-found without a search.
// The result sits in an output register; if the receiver stalls, a finished
// result waits in a holding register and no new word is taken until it moves.
// After reset the map is swept to undefined, one entry per cycle, over all 1024
// entries; input words are not accepted during the sweep, cfg writes are.
// map_length resets to 1024; values above 1024 act as 1024.
module nearest_defined_map_lookup
	import ndml_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [LW-1:0] cfg_data,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          kind,
	input  logic [AW-1:0] index,
	input  logic [VW-1:0] target_value,
	input  logic          target_defined,
	input  logic [1:0]    direction,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [VW-1:0] found_position,
	output logic          found
);

	localparam logic [1:0] ST_CLEAR  = 2'd0;
	localparam logic [1:0] ST_IDLE   = 2'd1;
	localparam logic [1:0] ST_SEARCH = 2'd2;
	localparam logic [1:0] ST_HOLD   = 2'd3;

	logic [1:0]    state_q;
	logic [AW-1:0] clr_q;
	logic [LW-1:0] map_length_q;
	logic [LW-1:0] len;
	logic          pend_q;
	logic [EW-1:0] rd_q;
	logic [EW-1:0] mem [DEPTH];

	logic          out_valid_q;
	logic [VW-1:0] out_pos_q;
	logic          out_found_q;
	logic [VW-1:0] hold_pos_q;
	logic          hold_found_q;

	walk_ctl_t     ctl;
	walk_t         walk;

	logic          accept;
	logic          idx_in;
	logic          hit;
	logic          fin;
	logic          fin_found;
	logic [VW-1:0] fin_pos;
	logic          slot_free;
	logic          load_out;
	logic          we;
	logic [AW-1:0] wa;
	logic [EW-1:0] wd;

	assign len       = (map_length_q > LW'(DEPTH)) ? LW'(DEPTH) : map_length_q;
	assign cfg_ready = 1'b1;
	assign in_ready  = state_q == ST_IDLE;
	assign accept    = in_valid & in_ready;
	assign idx_in    = LW'(index) < len;
	assign hit       = pend_q & rd_q[VW];
	assign slot_free = !out_valid_q | out_ready;
	assign load_out  = slot_free & (fin | (state_q == ST_HOLD));

	assign out_valid      = out_valid_q;
	assign found_position = out_pos_q;
	assign found          = out_found_q;

	always_comb begin
		ctl.start = accept & (kind == KIND_QUERY) & idx_in & (direction != DIR_BAD);
		ctl.step  = (state_q == ST_SEARCH) & !hit & walk.avail;
		ctl.idx   = index;
		ctl.dir   = direction;
		ctl.len   = len;
	end

	ndml_walk u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.walk   (walk)
	);

	// a result is finished on a hit, when no probe is left, or for a query that starts no search
	always_comb begin
		fin       = 1'b0;
		fin_found = 1'b0;
		fin_pos   = '0;
		unique case (state_q)
			ST_IDLE: begin
				fin = accept & (kind == KIND_QUERY) & !ctl.start;
			end
			ST_SEARCH: begin
				if (hit) begin
					fin       = 1'b1;
					fin_found = 1'b1;
					fin_pos   = rd_q[VW-1:0];
				end else if (!walk.avail) begin
					fin = 1'b1;
				end
			end
			default: begin
				fin = 1'b0;
			end
		endcase
	end

	always_comb begin
		we = 1'b0;
		wa = index;
		wd = {target_defined, target_value & {VW{target_defined}}};
		if (state_q == ST_CLEAR) begin
			we = 1'b1;
			wa = clr_q;
			wd = '0;
		end else if (accept && kind == KIND_WRITE && idx_in) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_q <= mem[walk.addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			map_length_q <= LW'(DEPTH);
			pend_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) map_length_q <= cfg_data;
			pend_q <= ctl.step;
			if (load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (ctl.start) begin
						state_q <= ST_SEARCH;
					end else if (fin && !slot_free) begin
						state_q <= ST_HOLD;
					end
				end
				ST_SEARCH: begin
					if (fin) begin
						if (slot_free) state_q <= ST_IDLE;
						else state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (slot_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result payload: straight to the output word, or parked while it stalls
	always_ff @(posedge clk) begin
		if (fin) begin
			hold_pos_q   <= fin_pos;
			hold_found_q <= fin_found;
			if (slot_free) begin
				out_pos_q   <= fin_pos;
				out_found_q <= fin_found;
			end
		end else if (state_q == ST_HOLD && slot_free) begin
			out_pos_q   <= hold_pos_q;
			out_found_q <= hold_found_q;
		end
	end

endmodule

// ----- tb/nearest_defined_map_lookup_test.sv -----
`timescale 1ns / 100ps
// nearest_defined_map_lookup_test: self-checking testbench of the nearest defined map lookup
// needs ndml_pkg and nearest_defined_map_lookup; predicts lookups from its own map image
module nearest_defined_map_lookup_test;
	import ndml_pkg::*;

	typedef struct packed {
		logic [VW-1:0] position;
		logic          hit;
	} lookup_t;

	logic          clk;
	logic          arst_n;
	logic          cfg_valid;
	logic          cfg_ready;
	logic [LW-1:0] cfg_data;
	logic          in_valid;
	logic          in_ready;
	logic          kind;
	logic [AW-1:0] index;
	logic [VW-1:0] target_value;
	logic          target_defined;
	logic [1:0]    direction;
	logic          out_valid;
	logic          out_ready;
	logic [VW-1:0] found_position;
	logic          found;

	lookup_t       pending_lookups[$];
	logic [EW-1:0] map_image[DEPTH];
	int            length_in_use = DEPTH;
	int            mismatches = 0;
	int            counted_items = 0;
	bit            steady = 1'b1;

	nearest_defined_map_lookup dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.index(index),
		.target_value(target_value),
		.target_defined(target_defined),
		.direction(direction),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.found_position(found_position),
		.found(found)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#25_000_000;
		$display("** nearest_defined_map_lookup: FAILED **");
		$finish;
	end

	function automatic lookup_t hit_at(int p);
		return '{position: map_image[p][VW-1:0], hit: 1'b1};
	endfunction

	function automatic lookup_t nearest_entry(int start, logic [1:0] dir);
		int n;
		int p;
		int d;
		n = (length_in_use > DEPTH) ? DEPTH : length_in_use;
		if (start >= n)
			return '0;
		case (dir)
		DIR_DOWN: begin
			for (p = start; p >= 0; p--)
				if (map_image[p][VW]) return hit_at(p);
			for (p = start + 1; p < n; p++)
				if (map_image[p][VW]) return hit_at(p);
		end
		DIR_UP: begin
			for (p = start; p < n; p++)
				if (map_image[p][VW]) return hit_at(p);
			for (p = start - 1; p >= 0; p--)
				if (map_image[p][VW]) return hit_at(p);
		end
		DIR_NEAREST: begin
			// lower side first at each distance
			for (d = 0; d <= start || start + d < n; d++) begin
				if (d <= start && map_image[start - d][VW]) return hit_at(start - d);
				if (start + d < n && map_image[start + d][VW]) return hit_at(start + d);
			end
		end
		default: ;
		endcase
		return '0;
	endfunction

	task automatic send_word(logic w_kind, logic [AW-1:0] w_index, logic [VW-1:0] w_value,
			logic w_defined, logic [1:0] w_dir);
		int gap;
		gap = steady ? 0 : $urandom_range(7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		kind           <= w_kind;
		index          <= w_index;
		target_value   <= w_value;
		target_defined <= w_defined;
		direction      <= w_dir;
		do @(posedge clk); while (!in_ready);
		if (w_kind == KIND_QUERY)
			pending_lookups.push_back(nearest_entry(int'(w_index), w_dir));
		else if (int'(w_index) < length_in_use)
			map_image[w_index] = w_defined ? {1'b1, w_value} : '0;
	endtask

	task automatic put_entry(logic [AW-1:0] at, logic [VW-1:0] value, logic defined);
		send_word(KIND_WRITE, at, value, defined, 2'($urandom_range(3)));
	endtask

	task automatic ask(logic [AW-1:0] at, logic [1:0] dir);
		send_word(KIND_QUERY, at, VW'($urandom_range(1023)), 1'($urandom_range(1)), dir);
	endtask

	// writes finish in their accept cycle, so a short pause covers them
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_lookups.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_length(int len);
		settle();
		cfg_valid <= 1'b1;
		cfg_data  <= len[LW-1:0];
		do @(posedge clk); while (!cfg_ready);
		length_in_use = len;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_empty_map();
		steady = 1'b1;
		ask('0, DIR_DOWN);
		ask(AW'(DEPTH - 1), DIR_UP);
		ask(AW'(DEPTH / 2), DIR_NEAREST);
		ask(10'd5, DIR_BAD);
	endtask

	task automatic test_search_order();
		steady = 1'b0;
		put_entry('0, 10'h3FF, 1'b1);
		put_entry(AW'(DEPTH - 1), '0, 1'b1);
		put_entry(10'd510, 10'h155, 1'b1);
		put_entry(10'd514, 10'h2AA, 1'b1);
		ask(10'd512, DIR_DOWN);
		ask(10'd512, DIR_UP);
		ask(10'd512, DIR_NEAREST);
		ask(AW'(DEPTH - 1), DIR_DOWN);
		ask(10'd1, DIR_UP);
		ask(10'd512, DIR_BAD);
		// clearing drops the value that rides along
		put_entry(10'd510, 10'h3FF, 1'b0);
		ask(10'd512, DIR_NEAREST);
		ask(10'd511, DIR_DOWN);
	endtask

	task automatic test_length_edges();
		write_length(600);
		ask(10'd700, DIR_NEAREST);
		put_entry(10'd700, 10'h0F0, 1'b1);
		ask(10'd599, DIR_UP);
		write_length(0);
		put_entry(10'd3, 10'h001, 1'b1);
		ask('0, DIR_NEAREST);
		write_length(1);
		ask('0, DIR_UP);
		write_length(2047);
		ask(AW'(DEPTH - 1), DIR_NEAREST);
		ask(10'd700, DIR_DOWN);
	endtask

	task automatic test_random_traffic();
		int len;
		int span;
		int fill;
		int density;
		int i;
		int pick;
		logic [AW-1:0] at;
		while (counted_items < 555) begin
			case ($urandom_range(9))
			0: len = $urandom_range(1) ? DEPTH : $urandom_range(DEPTH + 1, 2047);
			1: len = $urandom_range(2);
			2: len = $urandom_range(49, DEPTH - 1);
			default: len = $urandom_range(3, 48);
			endcase
			write_length(len);
			steady  = ($urandom_range(3) == 0);
			density = $urandom_range(10, 90);
			span    = (len > DEPTH) ? DEPTH : len;
			fill    = $urandom_range(2, 10);
			// fill a few entries first, then mix lookups with updates
			for (i = 0; i < fill + 22; i++) begin
				pick = (i < fill) ? 0 : $urandom_range(99);
				if (span == 0 || (pick >= 45 && pick < 55))
					at = AW'($urandom_range(DEPTH - 1));
				else
					at = AW'($urandom_range(span - 1));
				if (pick < 50)
					put_entry(at, VW'($urandom_range(1023)), $urandom_range(99) < density);
				else
					ask(at, ($urandom_range(15) == 0) ? DIR_BAD : 2'($urandom_range(2)));
				if (pick >= 50 || int'(at) < span)
					counted_items++;
			end
		end
	endtask

	initial begin : result_check
		int gap;
		lookup_t want;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = steady ? 0 : $urandom_range(7);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
			if (pending_lookups.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected word, expected none, got found_position %0d found %0b",
					$time, found_position, found);
			end else begin
				want = pending_lookups.pop_front();
				if (found_position !== want.position) begin
					mismatches++;
					$display("%0t: found_position expected %0d, got %0d",
						$time, want.position, found_position);
				end
				if (found !== want.hit) begin
					mismatches++;
					$display("%0t: found expected %0b, got %0b", $time, want.hit, found);
				end
			end
		end
	end

	initial begin
		arst_n         <= 1'b0;
		cfg_valid      <= 1'b0;
		cfg_data       <= '0;
		in_valid       <= 1'b0;
		kind           <= KIND_WRITE;
		index          <= '0;
		target_value   <= '0;
		target_defined <= 1'b0;
		direction      <= DIR_DOWN;
		foreach (map_image[i])
			map_image[i] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_map();
		test_search_order();
		test_length_edges();
		test_random_traffic();
		settle();
		// room for a full-length search to show a stray word
		repeat (1040) @(posedge clk);
		if (mismatches == 0)
			$display("** nearest_defined_map_lookup: PASSED **");
		else
			$display("** nearest_defined_map_lookup: FAILED **");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/ndml_pkg.sv
hdl/ndml_walk.sv
hdl/nearest_defined_map_lookup.sv
tb/nearest_defined_map_lookup_test.sv
